FILE: rtl/deq_pkg.sv
// deq_pkg: shared types and constants for the double-ended queue
// used by deq_cell and double_ended_queue; no dependencies
package deq_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned ODATA_W = 104;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_e;

  // data and occupancy handed between neighbouring cells
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] data;
  } deq_link_t;

  // command broadcast to every cell
  typedef struct packed {
    logic go;
    req_e op;
  } deq_cmd_t;

endpackage

FILE: rtl/deq_cell.sv
// deq_cell: one storage slot of the queue's shift chain
// depends on deq_pkg for the link and command types
module deq_cell import deq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  deq_cmd_t                 cmd_i,
  input  logic signed [DATA_W-1:0] data_i,
  input  deq_link_t                left_i,
  input  deq_link_t                right_i,
  output deq_link_t                link_o,
  output logic signed [DATA_W-1:0] back_data_o
);

  logic                     valid_q, valid_d;
  logic signed [DATA_W-1:0] data_q, data_d;
  logic                     is_back;

  assign is_back = valid_q && !right_i.valid;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (cmd_i.go) begin
      case (cmd_i.op)
        REQ_PUSH_FRONT: begin
          valid_d = left_i.valid;
          data_d  = left_i.data;
        end
        REQ_PUSH_BACK: begin
          // first free slot takes the new value
          if (left_i.valid && !valid_q) begin
            valid_d = 1'b1;
            data_d  = data_i;
          end
        end
        REQ_POP_FRONT: begin
          valid_d = right_i.valid;
          data_d  = right_i.data;
        end
        REQ_POP_BACK: begin
          if (is_back) valid_d = 1'b0;
        end
        default: begin
          valid_d = valid_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.data  = data_q;
  assign back_data_o  = is_back ? data_q : '0;

endmodule

FILE: rtl/double_ended_queue.sv
// double_ended_queue: top level, a row of deq_cell slots with front at slot 0
// depends on deq_pkg and deq_cell
//
// Usage: each request transaction on the s_axis side carries the operation in
// tuser (push front, push back, pop front, pop back) and the value in tdata.
// Every request gives exactly one result transaction on the m_axis side with
// the status, the popped value, the front and back entries after the request
// and the entry count.
// Latency: the result is valid the cycle after the request is taken.
// Throughput: one request per cycle while results are taken; the slots shift
// together, so the next request is taken in the same cycle the result leaves.
// A result register sits between the two sides: a request is taken whenever
// the register is empty or its result is being taken in the same cycle.
// When the receiver stalls the result holds and further requests wait.
// A push on a full queue is dropped, a pop on an empty queue changes nothing;
// both are flagged in the status.
// Reset empties the queue and the result register; no clearing pass is needed.
module double_ended_queue import deq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,  // data_in[31:0]
  input  logic [1:0]         s_axis_tuser,  // req_type[1:0]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // status[1:0], popped_value[33:2], front_value[65:34], back_value[97:66],
  // entry_count[102:98], zero pad[103]
  output logic [ODATA_W-1:0] m_axis_tdata
);

  req_e                     op;
  logic                     accept;
  logic                     full, empty, reject;
  deq_cmd_t                 cmd;
  deq_link_t                link   [DEPTH];
  logic signed [DATA_W-1:0] back_part [DEPTH];
  logic signed [DATA_W-1:0] front_val, back_val;

  logic                     out_valid_q, out_valid_d;
  status_e                  status_q, status_d;
  logic signed [DATA_W-1:0] popped_q, popped_d;
  logic [CNT_W-1:0]         count_q, count_d;

  assign op     = req_e'(s_axis_tuser);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);
  assign reject = ((op == REQ_PUSH_FRONT || op == REQ_PUSH_BACK) && full) ||
                  ((op == REQ_POP_FRONT || op == REQ_POP_BACK) && empty);

  assign cmd.go = accept && !reject;
  assign cmd.op = op;

  assign s_axis_tready = !out_valid_q || m_axis_tready;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    deq_link_t left, right;
    if (i == 0) begin : g_head
      assign left.valid = 1'b1;
      assign left.data  = s_axis_tdata;
    end else begin : g_mid
      assign left = link[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right.valid = 1'b0;
      assign right.data  = '0;
    end else begin : g_body
      assign right = link[i+1];
    end
    deq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .data_i      (s_axis_tdata),
      .left_i      (left),
      .right_i     (right),
      .link_o      (link[i]),
      .back_data_o (back_part[i])
    );
  end

  assign front_val = link[0].valid ? link[0].data : '0;

  // only the back slot drives a non-zero value
  always_comb begin
    back_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_val = back_val | back_part[i];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    popped_d    = popped_q;
    count_d     = count_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (accept) begin
      out_valid_d = 1'b1;
      status_d    = ST_DONE;
      popped_d    = '0;
      case (op)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (full) status_d = ST_PUSH_FULL;
          else      count_d  = count_q + CNT_W'(1);
        end
        REQ_POP_FRONT: begin
          if (empty) begin
            status_d = ST_POP_EMPTY;
          end else begin
            popped_d = front_val;
            count_d  = count_q - CNT_W'(1);
          end
        end
        REQ_POP_BACK: begin
          if (empty) begin
            status_d = ST_POP_EMPTY;
          end else begin
            popped_d = back_val;
            count_d  = count_q - CNT_W'(1);
          end
        end
        default: begin
          status_d = ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    popped_q <= popped_d;
  end

  // front and back come straight from the slots, which hold still until the
  // pending result transaction completes
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, count_q, back_val, front_val, popped_q, status_q};

endmodule
